// ===== rtl/sule_pkg.sv =====
// ----------------------------------------------------------------------------
// sule_pkg: shared types and constants for the sorted unique list engine
// Request and status codes, default sizing, controller/datapath interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sule_pkg;

  localparam int DATA_W           = 32;
  localparam int REQ_W            = 2;
  localparam int STAT_W           = 2;
  localparam int OUT_W            = 6;
  localparam int DEFAULT_CAPACITY = 32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABSENT  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic              load;      // capture request, open search window
    logic              look_rd;   // read entry at window midpoint
    logic              step;      // compare read data, narrow window
    logic              sh_init;   // set shift pointer
    logic              sh_rd;     // read neighbor of shift pointer
    logic              sh_wr;     // write read data at shift pointer, advance
    logic              fix;       // insert: place value, count up; remove: count down
    logic              res_set;   // latch status code
    logic [STAT_W-1:0] res_code;
    logic              emit;      // load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic srch_done;
    logic hit;
    logic full;
    logic is_ins;
    logic is_rem;
    logic sh_more;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/sule_ctrl.sv =====
// ----------------------------------------------------------------------------
// sule_ctrl: request sequencer
// Steps the binary search, the shift loop and the result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sule_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire sule_pkg::sts_t sts,
  output sule_pkg::cmd_t     cmd
);
  import sule_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOOK  = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_SHCHK = 4'd4;
  localparam logic [3:0] S_SHRD  = 4'd5;
  localparam logic [3:0] S_SHWR  = 4'd6;
  localparam logic [3:0] S_FIX   = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0] state, state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts.srch_done) begin
          state_next = S_DEC;
        end else begin
          cmd.look_rd = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        cmd.step   = 1'b1;
        state_next = S_LOOK;
      end
      S_DEC: begin
        cmd.res_set = 1'b1;
        if (sts.is_ins) begin
          if (sts.hit) begin
            cmd.res_code = ST_PRESENT;
            state_next   = S_EMIT;
          end else if (sts.full) begin
            cmd.res_code = ST_FULL;
            state_next   = S_EMIT;
          end else begin
            cmd.res_code = ST_DONE;
            cmd.sh_init  = 1'b1;
            state_next   = S_SHCHK;
          end
        end else if (sts.is_rem) begin
          if (sts.hit) begin
            cmd.res_code = ST_DONE;
            cmd.sh_init  = 1'b1;
            state_next   = S_SHCHK;
          end else begin
            cmd.res_code = ST_ABSENT;
            state_next   = S_EMIT;
          end
        end else begin
          cmd.res_code = sts.hit ? ST_DONE : ST_ABSENT;
          state_next   = S_EMIT;
        end
      end
      S_SHCHK: begin
        state_next = sts.sh_more ? S_SHRD : S_FIX;
      end
      S_SHRD: begin
        cmd.sh_rd  = 1'b1;
        state_next = S_SHWR;
      end
      S_SHWR: begin
        cmd.sh_wr  = 1'b1;
        state_next = S_SHCHK;
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sule_dp.sv =====
// ----------------------------------------------------------------------------
// sule_dp: list storage and search/shift datapath
// Single-port-pair entry memory, search window, shift pointer, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sule_dp #(
  parameter int CAPACITY = sule_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [sule_pkg::REQ_W-1:0]      req_type,
  input  wire logic signed [sule_pkg::DATA_W-1:0] value,
  input  wire logic                            rsp_stall,
  output logic                                 rsp_valid,
  output logic [sule_pkg::STAT_W-1:0]          status,
  output logic [sule_pkg::OUT_W-1:0]           position,
  output logic [sule_pkg::OUT_W-1:0]           count,
  input  wire sule_pkg::cmd_t                  cmd,
  output sule_pkg::sts_t                       sts
);
  import sule_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rdata;

  logic [REQ_W-1:0]         req;
  logic signed [DATA_W-1:0] val;
  logic [CW-1:0]            n_ent;
  logic [CW-1:0]            lo, hi, ptr;
  logic [AW-1:0]            mid_q;
  logic                     hit;
  logic [STAT_W-1:0]        res_code;

  logic [CW:0]              mid_sum;
  logic [AW-1:0]            mid;
  logic                     is_ins, is_rem;
  logic [AW-1:0]            rd_addr, wr_addr, sh_rd_addr;
  logic                     rd_en, wr_en;
  logic signed [DATA_W-1:0] wr_data;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[AW:1];
  assign is_ins  = (req == REQ_INSERT);
  assign is_rem  = (req == REQ_REMOVE);

  // insert moves entry ptr-1 up to ptr; remove moves entry ptr+1 down to ptr
  assign sh_rd_addr = is_ins ? AW'(ptr - CW'(1)) : AW'(ptr + CW'(1));
  assign rd_en      = cmd.look_rd | cmd.sh_rd;
  assign rd_addr    = cmd.sh_rd ? sh_rd_addr : mid;
  assign wr_en      = cmd.sh_wr | (cmd.fix & is_ins);
  assign wr_addr    = cmd.sh_wr ? AW'(ptr) : AW'(lo);
  assign wr_data    = cmd.sh_wr ? rdata : val;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // search window and shift pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= req_type;
      val <= value;
      lo  <= '0;
      hi  <= n_ent;
      hit <= 1'b0;
    end
    if (cmd.look_rd) begin
      mid_q <= mid;
    end
    if (cmd.step) begin
      if (rdata < val) begin
        lo <= CW'(mid_q) + CW'(1);
      end else begin
        hi  <= CW'(mid_q);
        hit <= (rdata == val);
      end
    end
    if (cmd.sh_init) begin
      ptr <= is_ins ? n_ent : lo;
    end else if (cmd.sh_wr) begin
      ptr <= is_ins ? ptr - CW'(1) : ptr + CW'(1);
    end
    if (cmd.res_set) begin
      res_code <= cmd.res_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_ent <= '0;
    end else if (cmd.fix) begin
      n_ent <= is_ins ? n_ent + CW'(1) : n_ent - CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status   <= res_code;
      position <= OUT_W'(lo);
      count    <= OUT_W'(n_ent);
    end
  end

  always_comb begin
    sts.srch_done = (lo == hi);
    sts.hit       = hit;
    sts.full      = (n_ent == CW'(CAPACITY));
    sts.is_ins    = is_ins;
    sts.is_rem    = is_rem;
    sts.sh_more   = is_ins ? (ptr > lo) : (({1'b0, ptr} + (CW+1)'(1)) < {1'b0, n_ent});
    sts.out_busy  = rsp_valid & rsp_stall;
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_unique_list_engine.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_list_engine: ascending list of distinct signed 32-bit values
// Holds up to CAPACITY distinct values in ascending signed order in an
// on-chip memory with one read and one write port. A request transaction is
// an insert, a remove or a search; each gives exactly one response
// transaction carrying a status (done/found, already present, not present,
// list full), the position of the first entry not smaller than the value
// (taken before any change) and the entry count after the request. The
// position is found by a binary search over the memory, each probe a read
// and then a compare since the read data is registered; an insert then
// moves every larger entry up one slot and a remove moves every later entry
// down one slot, each moved entry a check, a read and a write, through
// the same memory ports. One request is in work at a time; req_stall stays
// high from acceptance until the result is loaded into the response
// register, and a new request is accepted while that result still waits
// downstream. The memory needs no clearing after reset: only entries below
// the count are ever read. An unused request code acts as a search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_unique_list_engine #(
  parameter int CAPACITY = sule_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // request channel
  input  wire logic                               req_valid,
  output logic                                    req_stall,
  input  wire logic [sule_pkg::REQ_W-1:0]         req_type,
  input  wire logic signed [sule_pkg::DATA_W-1:0] value,
  // response channel
  output logic                                    rsp_valid,
  input  wire logic                               rsp_stall,
  output logic [sule_pkg::STAT_W-1:0]             status,
  output logic [sule_pkg::OUT_W-1:0]              position,
  output logic [sule_pkg::OUT_W-1:0]              count
);
  import sule_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: search probes, shift loop, result hand-off
  sule_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // entry memory, search window, count and response register
  sule_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_type  (req_type),
    .value     (value),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .status    (status),
    .position  (position),
    .count     (count),
    .cmd       (cmd),
    .sts       (sts)
  );

  // a finished result never overwrites one that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !sts.out_busy)
    else $error("result loaded over a stalled response");

  // an insert only places a value when there is room
  a_fix_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.fix && sts.is_ins) |-> !sts.full)
    else $error("insert into a full list");

  // a full status is only reported with the list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_FULL) |-> (count == OUT_W'(CAPACITY)))
    else $error("full status with room left");

  // one request at a time: acceptance closes the request channel
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request channel open while a request is in work");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking regression for sorted_unique_list_engine
// Drives insert, remove and search transactions through the request channel.
// A scoreboard keeps its own ascending copy of the list and predicts status,
// position and count for every accepted request. Responses are checked in
// order. Traffic runs in phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Keeps a private copy of the sorted list and a FIFO of predicted responses.
class list_scoreboard;
  typedef struct {
    logic [sule_pkg::STAT_W-1:0] status;
    logic [sule_pkg::OUT_W-1:0]  position;
    logic [sule_pkg::OUT_W-1:0]  count;
  } list_result_t;

  logic signed [sule_pkg::DATA_W-1:0] held[$];   // ascending, distinct
  list_result_t                       predicted[$];
  int                                 mismatches;

  function new();
    mismatches = 0;
  endfunction

  function int pending();
    return predicted.size();
  endfunction

  function void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: MISMATCH %s", $time, msg);
  endfunction

  // Predict the response to one accepted request and update the list.
  function void note_request(logic [sule_pkg::REQ_W-1:0] kind,
                             logic signed [sule_pkg::DATA_W-1:0] v);
    int           slot;
    bit           hit;
    list_result_t r;
    slot = 0;
    while (slot < held.size() && held[slot] < v) slot++;
    hit = (slot < held.size()) && (held[slot] == v);
    case (kind)
      sule_pkg::REQ_INSERT: begin
        if (hit) begin
          r.status = sule_pkg::ST_PRESENT;
        end else if (held.size() >= sule_pkg::DEFAULT_CAPACITY) begin
          r.status = sule_pkg::ST_FULL;
        end else begin
          held.insert(slot, v);
          r.status = sule_pkg::ST_DONE;
        end
      end
      sule_pkg::REQ_REMOVE: begin
        if (hit) begin
          held.delete(slot);
          r.status = sule_pkg::ST_DONE;
        end else begin
          r.status = sule_pkg::ST_ABSENT;
        end
      end
      default: begin
        r.status = hit ? sule_pkg::ST_DONE : sule_pkg::ST_ABSENT;
      end
    endcase
    r.position = slot[sule_pkg::OUT_W-1:0];
    r.count    = sule_pkg::OUT_W'(held.size());
    predicted.push_back(r);
  endfunction

  // Compare one accepted response with the oldest prediction.
  function void check_response(logic [sule_pkg::STAT_W-1:0] got_status,
                               logic [sule_pkg::OUT_W-1:0]  got_position,
                               logic [sule_pkg::OUT_W-1:0]  got_count);
    list_result_t r;
    if (predicted.size() == 0) begin
      flag($sformatf("response with none pending: status %0d position %0d count %0d",
                     got_status, got_position, got_count));
      return;
    end
    r = predicted.pop_front();
    if (got_status !== r.status)
      flag($sformatf("status expected %0d got %0d", r.status, got_status));
    if (got_position !== r.position)
      flag($sformatf("position expected %0d got %0d", r.position, got_position));
    if (got_count !== r.count)
      flag($sformatf("count expected %0d got %0d", r.count, got_count));
  endfunction
endclass

module testbench;
  import sule_pkg::*;

  localparam int                 LIST_DEPTH     = DEFAULT_CAPACITY;
  localparam int                 RANDOM_ITEMS   = 830;
  localparam int                 PHASES         = 5;
  localparam int                 LONG_HOLD      = 400;   // receiver hold-off, cycles
  localparam int                 WATCHDOG_LIMIT = 6000;  // quiet cycles before giving up
  localparam int                 TAIL_CYCLES    = 300;   // settle time after last response
  localparam int                 POOL_SIZE      = 40;
  // request code 3 is unused; the block treats it as a search
  localparam logic [REQ_W-1:0]   REQ_UNUSED     = 2'd3;
  localparam logic signed [31:0] INT_MIN        = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX        = 32'sh7FFF_FFFF;

  typedef enum int { MIX_FILL, MIX_DRAIN, MIX_BALANCED } traffic_mode_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     req_valid = 1'b0;
  logic [REQ_W-1:0]         req_type  = '0;
  logic signed [DATA_W-1:0] value     = '0;
  logic                     rsp_stall = 1'b0;
  logic                     req_stall;
  logic                     rsp_valid;
  logic [STAT_W-1:0]        status;
  logic [OUT_W-1:0]         position;
  logic [OUT_W-1:0]         count;

  sorted_unique_list_engine #(
    .CAPACITY (LIST_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .value     (value),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .position  (position),
    .count     (count)
  );

  always #5 clk = ~clk;

  list_scoreboard           sb;
  int                       send_idle_pct = 0;   // sender idle chance per cycle, percent
  int                       rsp_stall_pct = 0;   // receiver stall chance per cycle, percent
  bit                       hold_request  = 1'b0;
  int                       quiet_cycles  = 0;
  logic signed [DATA_W-1:0] value_pool[POOL_SIZE];

  // --------------------------------------------------------------------------
  // Receiver: random stall, plus a long hold-off on request. The hold is
  // counted here so the sender keeps offering transactions meanwhile, which
  // backs the block up until it stalls its request side.
  // --------------------------------------------------------------------------
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Response monitor: every accepted response goes to the scoreboard
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(status, position, count);
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any accepted transaction ends the run
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog expired, %0d responses outstanding", $time, sb.pending());
      $display("sorted_unique_list_engine regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request driver. Payload changes only at the falling edge; valid stays
  // high from one transaction to the next unless an idle gap is drawn.
  // Acceptance is seen at the rising edge, where the prediction is made.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [REQ_W-1:0] kind,
                              input logic signed [DATA_W-1:0] v);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    req_valid = 1'b1;
    req_type  = kind;
    value     = v;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(kind, v);
  endtask

  task automatic release_request();
    @(negedge clk);
    req_valid = 1'b0;
  endtask

  // Sender pause: nothing new until every predicted response is back.
  task automatic wait_for_responses();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Most often values already held (hits), then a shared pool (repeats and
  // near-misses), the numeric extremes, zero and minus one, and fully random words.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40 && sb.held.size() > 0) return sb.held[$urandom_range(sb.held.size() - 1)];
    if (sel < 70) return value_pool[$urandom_range(POOL_SIZE - 1)];
    if (sel < 80) begin
      case ($urandom_range(5))
        0:       return INT_MIN;
        1:       return INT_MIN + 1;
        2:       return INT_MAX;
        3:       return INT_MAX - 1;
        4:       return 0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  // Request mix per traffic mode: fill pushes toward a full list, drain
  // toward an empty one, balanced keeps hovering.
  function automatic logic [REQ_W-1:0] pick_kind(traffic_mode_t mode);
    int sel;
    int ins_pct;
    int rem_pct;
    sel = $urandom_range(99);
    case (mode)
      MIX_FILL:  begin ins_pct = 85; rem_pct = 5;  end
      MIX_DRAIN: begin ins_pct = 15; rem_pct = 75; end
      default:   begin ins_pct = 40; rem_pct = 30; end
    endcase
    if (sel < ins_pct) return REQ_INSERT;
    if (sel < ins_pct + rem_pct) return REQ_REMOVE;
    if (sel < 97) return REQ_SEARCH;
    return REQ_UNUSED;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int            sent;
    int            seg_left;
    int            phase;
    traffic_mode_t mode;

    sb = new();
    foreach (value_pool[i]) value_pool[i] = $urandom;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty list, extremes, duplicates, misses, unused code,
    // removal at head, tail and middle.
    send_request(REQ_SEARCH, 0);            // search of empty list
    send_request(REQ_REMOVE, 5);            // remove from empty list
    send_request(REQ_INSERT, 0);
    send_request(REQ_INSERT, INT_MIN);
    send_request(REQ_INSERT, INT_MAX);
    send_request(REQ_INSERT, -1);
    send_request(REQ_INSERT, 1);
    send_request(REQ_INSERT, 0);            // duplicate
    send_request(REQ_INSERT, INT_MAX);      // duplicate at tail
    send_request(REQ_SEARCH, INT_MIN);      // hit at head
    send_request(REQ_SEARCH, INT_MAX);      // hit at tail
    send_request(REQ_SEARCH, 2);            // miss in the middle
    send_request(REQ_SEARCH, INT_MAX - 1);  // miss just below tail
    send_request(REQ_UNUSED, 1);            // unused code acts as search, hit
    send_request(REQ_UNUSED, 7);            // unused code, miss
    send_request(REQ_REMOVE, INT_MIN);      // head
    send_request(REQ_REMOVE, 100);          // missing
    send_request(REQ_REMOVE, INT_MAX);      // tail
    send_request(REQ_REMOVE, 0);            // middle
    send_request(REQ_INSERT, 32'sh5555_5555);
    send_request(REQ_INSERT, 32'shAAAA_AAAA);
    send_request(REQ_SEARCH, 32'sh5555_5555);
    release_request();
    wait_for_responses();

    // Random traffic in idling phases; each phase ends with a full drain.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1:       begin send_idle_pct = 88; rsp_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  rsp_stall_pct = 88; end
        3:       begin send_idle_pct = 34; rsp_stall_pct = 34; end
        default: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
      endcase
      // last phase: receiver holds off while the sender keeps pushing
      if (phase == PHASES - 1) hold_request = 1'b1;
      seg_left = 0;
      mode     = MIX_BALANCED;
      for (sent = 0; sent < RANDOM_ITEMS / PHASES; sent++) begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 45);
          case ($urandom_range(2))
            0:       mode = MIX_FILL;
            1:       mode = MIX_DRAIN;
            default: mode = MIX_BALANCED;
          endcase
        end
        seg_left--;
        send_request(pick_kind(mode), pick_value());
      end
      release_request();
      wait_for_responses();
    end

    // Let any stray response show up before judging.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("sorted_unique_list_engine regression: pass");
    end else begin
      $display("sorted_unique_list_engine regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sule_pkg.sv
rtl/sule_ctrl.sv
rtl/sule_dp.sv
rtl/sorted_unique_list_engine.sv
verif/testbench.sv
